>>> rtl/dtp_pkg.sv
// Shared constants and codes of the deadline timer profiler.
package dtp_pkg;

    localparam int NUM_TIMERS    = 4;
    localparam int WINDOW_DEPTH  = 16;
    localparam int FRACTION_BITS = 8;

    localparam int OP_W      = 2;
    localparam int SLOT_W    = 2;
    localparam int KIND_W    = 2;
    localparam int TICK_W    = 32;
    localparam int MEAN_W    = 40;
    localparam int HORIZON_W = 5;
    localparam int MASK_W    = 4;
    localparam int CFG_IDX_W = 3;

    localparam int FILL_W      = $clog2(WINDOW_DEPTH + 1);
    localparam int OLD_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int TOTAL_W     = TICK_W + $clog2(WINDOW_DEPTH);
    localparam int DIVD_W      = TOTAL_W + FRACTION_BITS;
    localparam int STORE_DEPTH = NUM_TIMERS * WINDOW_DEPTH;

    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_START   = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP    = 2'd2;
    localparam logic [OP_W-1:0] OP_PROFILE = 2'd3;

    localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STOP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PROFILE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HORIZON        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADLINE_ZERO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADLINE_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADLINE_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADLINE_THREE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK   = 3'd5;

endpackage

>>> rtl/dtp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/dtp_divider.sv
// Restoring divider, one quotient bit per cycle, for the window mean.
module dtp_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dtp_pkg::DIVD_W-1:0]  dividend,
    input  logic [dtp_pkg::FILL_W-1:0]  divisor,
    output logic                        done,
    output logic [dtp_pkg::DIVD_W-1:0]  quotient
);
    import dtp_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] work_reg, work_next;
    logic [FILL_W-1:0] rem_reg, rem_next;
    logic [FILL_W-1:0] divisor_reg, divisor_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [FILL_W:0]   trial;
    logic              fits;

    always_comb
    begin
        trial        = {rem_reg, work_reg[DIVD_W-1]};
        fits         = trial >= {1'b0, divisor_reg};
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start)
        begin
            work_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
            cnt_next     = '0;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DIVD_W-2:0], fits};
            rem_next  = fits ? FILL_W'(trial - {1'b0, divisor_reg}) : FILL_W'(trial);
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

>>> rtl/deadline_timer_profiler.sv
// Deadline timer profiler: timer slots, miss tracking and sliding window means.
// Tick gives no result; start and stop give their result in the cycle after they are accepted.
// Profile scans the slots in order; each present slot gets a window check, a drop of old entries
// (read, then subtract), a push, the bit-serial divider and a result; absent slots are skipped.
// The input is stalled while a profile runs or while a result waits to be taken.
// Reset initialises slot and control state, not result data or window memory; fill counts guard it.
module deadline_timer_profiler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dtp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dtp_pkg::TICK_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dtp_pkg::OP_W-1:0]       opcode,
    input  logic [dtp_pkg::SLOT_W-1:0]     timer_index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [dtp_pkg::KIND_W-1:0]     result_kind,
    output logic [dtp_pkg::SLOT_W-1:0]     slot_index,
    output logic                           ok,
    output logic                           deadline_missed,
    output logic [dtp_pkg::TICK_W-1:0]     miss_total,
    output logic [dtp_pkg::TICK_W-1:0]     latest_miss_ticks,
    output logic [dtp_pkg::TICK_W-1:0]     last_ticks,
    output logic [dtp_pkg::MEAN_W-1:0]     mean_ticks,
    output logic                           any_missed,
    output logic                           last
);
    import dtp_pkg::*;

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int POS_W  = FILL_W + 1;
    localparam int ST_W   = 3;

    localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
    localparam logic [ST_W-1:0] ST_SCAN     = 3'd1;
    localparam logic [ST_W-1:0] ST_DROP_RD  = 3'd2;
    localparam logic [ST_W-1:0] ST_DROP_SUB = 3'd3;
    localparam logic [ST_W-1:0] ST_PUSH     = 3'd4;
    localparam logic [ST_W-1:0] ST_DIV      = 3'd5;
    localparam logic [ST_W-1:0] ST_OUT      = 3'd6;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);

    logic [HORIZON_W-1:0] horizon_reg, horizon_next;
    logic [TICK_W-1:0]    deadline_reg [4];
    logic [TICK_W-1:0]    deadline_next [4];
    logic [MASK_W-1:0]    mask_reg, mask_next;

    logic [TICK_W-1:0]  now_reg, now_next;
    logic [TICK_W-1:0]  stamp_reg [NUM_TIMERS];
    logic [TICK_W-1:0]  stamp_next [NUM_TIMERS];
    logic               started_reg [NUM_TIMERS];
    logic               started_next [NUM_TIMERS];
    logic [TICK_W-1:0]  measured_reg [NUM_TIMERS];
    logic [TICK_W-1:0]  measured_next [NUM_TIMERS];
    logic               flag_reg [NUM_TIMERS];
    logic               flag_next [NUM_TIMERS];
    logic [TICK_W-1:0]  count_reg [NUM_TIMERS];
    logic [TICK_W-1:0]  count_next [NUM_TIMERS];
    logic [TICK_W-1:0]  latest_reg [NUM_TIMERS];
    logic [TICK_W-1:0]  latest_next [NUM_TIMERS];
    logic [FILL_W-1:0]  fill_reg [NUM_TIMERS];
    logic [FILL_W-1:0]  fill_next [NUM_TIMERS];
    logic [OLD_W-1:0]   oldest_reg [NUM_TIMERS];
    logic [OLD_W-1:0]   oldest_next [NUM_TIMERS];
    logic [TOTAL_W-1:0] total_reg [NUM_TIMERS];
    logic [TOTAL_W-1:0] total_next [NUM_TIMERS];

    logic [ST_W-1:0]   state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [MEAN_W-1:0] avg_reg, avg_next;

    logic              ov_reg, ov_next;
    logic [KIND_W-1:0] okind_reg, okind_next;
    logic [SLOT_W-1:0] oslot_reg, oslot_next;
    logic              ook_reg, ook_next;
    logic              omiss_reg, omiss_next;
    logic [TICK_W-1:0] ototal_reg, ototal_next;
    logic [TICK_W-1:0] olatest_reg, olatest_next;
    logic [TICK_W-1:0] olastt_reg, olastt_next;
    logic [MEAN_W-1:0] omean_reg, omean_next;
    logic              oany_reg, oany_next;
    logic              olast_reg, olast_next;

    logic [NUM_TIMERS-1:0] exists;
    logic                  later_exists;
    logic                  any_flag;
    logic                  in_fire;
    logic                  out_free;
    logic                  slot_valid;
    logic [FILL_W-1:0]     h_eff;
    logic [POS_W-1:0]      pos_sum;
    logic [OLD_W-1:0]      pos;
    logic [OLD_W-1:0]      oldest_inc;
    logic [TICK_W-1:0]     elapsed;
    logic [TOTAL_W-1:0]    pushed_total;

    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [TICK_W-1:0]  ram_rd_data;
    logic               div_start;
    logic               div_done;
    logic [DIVD_W-1:0]  div_quot;

    dtp_ram #(
        .WIDTH (TICK_W),
        .DEPTH (STORE_DEPTH)
    ) u_window_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (measured_reg[slot_reg]),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    dtp_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({pushed_total, FRACTION_BITS'(0)}),
        .divisor  (fill_reg[slot_reg] + FILL_W'(1)),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign cfg_ready = 1'b1;
    assign out_free  = !ov_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || (ov_reg && out_stall);
    assign in_fire   = in_valid && !in_stall;

    always_comb
    begin
        later_exists = 1'b0;
        any_flag     = 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            exists[i] = started_reg[i] || mask_reg[i];
            if (exists[i] && (i > int'(slot_reg)))
            begin
                later_exists = 1'b1;
            end
            if (exists[i] && flag_reg[i])
            begin
                any_flag = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (horizon_reg == '0)
        begin
            h_eff = FILL_W'(1);
        end
        else if (int'(horizon_reg) > WINDOW_DEPTH)
        begin
            h_eff = FILL_W'(WINDOW_DEPTH);
        end
        else
        begin
            h_eff = FILL_W'(horizon_reg);
        end
        pos_sum = POS_W'(oldest_reg[slot_reg]) + POS_W'(fill_reg[slot_reg]);
        if (pos_sum >= POS_W'(WINDOW_DEPTH))
        begin
            pos = OLD_W'(pos_sum - POS_W'(WINDOW_DEPTH));
        end
        else
        begin
            pos = OLD_W'(pos_sum);
        end
        if (oldest_reg[slot_reg] == OLD_W'(WINDOW_DEPTH - 1))
        begin
            oldest_inc = '0;
        end
        else
        begin
            oldest_inc = oldest_reg[slot_reg] + OLD_W'(1);
        end
        ram_wr_addr  = ADDR_W'(slot_reg) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(pos);
        ram_rd_addr  = ADDR_W'(slot_reg) * ADDR_W'(WINDOW_DEPTH)
                       + ADDR_W'(oldest_reg[slot_reg]);
        pushed_total = total_reg[slot_reg] + TOTAL_W'(measured_reg[slot_reg]);
        slot_valid   = int'(timer_index) < NUM_TIMERS;
        elapsed      = now_reg - stamp_reg[timer_index];
    end

    always_comb
    begin
        horizon_next  = horizon_reg;
        deadline_next = deadline_reg;
        mask_next     = mask_reg;
        now_next      = now_reg;
        stamp_next    = stamp_reg;
        started_next  = started_reg;
        measured_next = measured_reg;
        flag_next     = flag_reg;
        count_next    = count_reg;
        latest_next   = latest_reg;
        fill_next     = fill_reg;
        oldest_next   = oldest_reg;
        total_next    = total_reg;
        state_next    = state_reg;
        slot_next     = slot_reg;
        avg_next      = avg_reg;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        div_start     = 1'b0;

        ov_next      = ov_reg && out_stall;
        okind_next   = okind_reg;
        oslot_next   = oslot_reg;
        ook_next     = ook_reg;
        omiss_next   = omiss_reg;
        ototal_next  = ototal_reg;
        olatest_next = olatest_reg;
        olastt_next  = olastt_reg;
        omean_next   = omean_reg;
        oany_next    = oany_reg;
        olast_next   = olast_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_HORIZON:        horizon_next     = HORIZON_W'(cfg_data);
                REG_DEADLINE_ZERO:  deadline_next[0] = cfg_data;
                REG_DEADLINE_ONE:   deadline_next[1] = cfg_data;
                REG_DEADLINE_TWO:   deadline_next[2] = cfg_data;
                REG_DEADLINE_THREE: deadline_next[3] = cfg_data;
                REG_PRESENT_MASK:   mask_next        = MASK_W'(cfg_data);
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    okind_next   = KIND_START;
                    oslot_next   = timer_index;
                    ook_next     = 1'b0;
                    omiss_next   = 1'b0;
                    ototal_next  = '0;
                    olatest_next = '0;
                    olastt_next  = '0;
                    omean_next   = '0;
                    oany_next    = 1'b0;
                    olast_next   = 1'b1;
                    case (opcode)
                        OP_TICK:
                        begin
                            now_next = now_reg + TICK_W'(1);
                        end
                        OP_START:
                        begin
                            ov_next = 1'b1;
                            if (slot_valid)
                            begin
                                stamp_next[timer_index]   = now_reg;
                                started_next[timer_index] = 1'b1;
                                flag_next[timer_index]    = 1'b0;
                                ook_next     = 1'b1;
                                ototal_next  = count_reg[timer_index];
                                olatest_next = latest_reg[timer_index];
                                olastt_next  = measured_reg[timer_index];
                            end
                        end
                        OP_STOP:
                        begin
                            ov_next    = 1'b1;
                            okind_next = KIND_STOP;
                            if (slot_valid && exists[timer_index])
                            begin
                                measured_next[timer_index] = elapsed;
                                ook_next     = 1'b1;
                                omiss_next   = flag_reg[timer_index];
                                ototal_next  = count_reg[timer_index];
                                olatest_next = latest_reg[timer_index];
                                olastt_next  = elapsed;
                                if (elapsed > deadline_reg[timer_index])
                                begin
                                    flag_next[timer_index]   = 1'b1;
                                    latest_next[timer_index] = elapsed;
                                    omiss_next   = 1'b1;
                                    olatest_next = elapsed;
                                    if (count_reg[timer_index] != '1)
                                    begin
                                        count_next[timer_index] =
                                            count_reg[timer_index] + TICK_W'(1);
                                        ototal_next = count_reg[timer_index] + TICK_W'(1);
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            okind_next = KIND_PROFILE;
                            if (exists == '0)
                            begin
                                ov_next    = 1'b1;
                                oslot_next = '0;
                            end
                            else
                            begin
                                slot_next  = '0;
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (exists[slot_reg])
                begin
                    state_next = ST_DROP_RD;
                end
                else if (slot_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            ST_DROP_RD:
            begin
                if (fill_reg[slot_reg] >= h_eff)
                begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_DROP_SUB;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_DROP_SUB:
            begin
                total_next[slot_reg]  = total_reg[slot_reg] - TOTAL_W'(ram_rd_data);
                oldest_next[slot_reg] = oldest_inc;
                fill_next[slot_reg]   = fill_reg[slot_reg] - FILL_W'(1);
                state_next            = ST_DROP_RD;
            end
            ST_PUSH:
            begin
                ram_wr_en            = 1'b1;
                div_start            = 1'b1;
                total_next[slot_reg] = pushed_total;
                fill_next[slot_reg]  = fill_reg[slot_reg] + FILL_W'(1);
                state_next           = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = MEAN_W'(div_quot);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    okind_next   = KIND_PROFILE;
                    oslot_next   = slot_reg;
                    ook_next     = 1'b1;
                    omiss_next   = flag_reg[slot_reg];
                    ototal_next  = count_reg[slot_reg];
                    olatest_next = latest_reg[slot_reg];
                    olastt_next  = measured_reg[slot_reg];
                    omean_next   = avg_reg;
                    oany_next    = !later_exists && any_flag;
                    olast_next   = !later_exists;
                    if (later_exists)
                    begin
                        slot_next  = slot_reg + SLOT_W'(1);
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_reg <= HORIZON_W'(16);
            for (int i = 0; i < 4; i++)
            begin
                deadline_reg[i] <= '1;
            end
            mask_reg  <= '0;
            now_reg   <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                stamp_reg[i]    <= '0;
                started_reg[i]  <= 1'b0;
                measured_reg[i] <= '0;
                flag_reg[i]     <= 1'b0;
                count_reg[i]    <= '0;
                latest_reg[i]   <= '0;
                fill_reg[i]     <= '0;
                oldest_reg[i]   <= '0;
                total_reg[i]    <= '0;
            end
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            horizon_reg  <= horizon_next;
            deadline_reg <= deadline_next;
            mask_reg     <= mask_next;
            now_reg      <= now_next;
            stamp_reg    <= stamp_next;
            started_reg  <= started_next;
            measured_reg <= measured_next;
            flag_reg     <= flag_next;
            count_reg    <= count_next;
            latest_reg   <= latest_next;
            fill_reg     <= fill_next;
            oldest_reg   <= oldest_next;
            total_reg    <= total_next;
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg     <= avg_next;
        okind_reg   <= okind_next;
        oslot_reg   <= oslot_next;
        ook_reg     <= ook_next;
        omiss_reg   <= omiss_next;
        ototal_reg  <= ototal_next;
        olatest_reg <= olatest_next;
        olastt_reg  <= olastt_next;
        omean_reg   <= omean_next;
        oany_reg    <= oany_next;
        olast_reg   <= olast_next;
    end

    assign out_valid         = ov_reg;
    assign result_kind       = okind_reg;
    assign slot_index        = oslot_reg;
    assign ok                = ook_reg;
    assign deadline_missed   = omiss_reg;
    assign miss_total        = ototal_reg;
    assign latest_miss_ticks = olatest_reg;
    assign last_ticks        = olastt_reg;
    assign mean_ticks        = omean_reg;
    assign any_missed        = oany_reg;
    assign last              = olast_reg;

endmodule

>>> tb/deadline_timer_profiler_test.sv
// Self-checking testbench of the deadline timer profiler with its own timer and window predictor.
`timescale 1ns / 100ps

module deadline_timer_profiler_test;
    import dtp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 200;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic              ok;
        logic              missed;
        logic [TICK_W-1:0] miss_total;
        logic [TICK_W-1:0] latest_miss;
        logic [TICK_W-1:0] last_ticks;
        logic [MEAN_W-1:0] mean;
        logic              any_flag;
        logic              is_last;
    } timer_report_t;

    class timer_scoreboard;
        timer_report_t         expected_reports[$];
        int                    report_errors;
        logic [HORIZON_W-1:0]  horizon;
        logic [TICK_W-1:0]     deadline[NUM_TIMERS];
        logic [MASK_W-1:0]     present;
        logic [TICK_W-1:0]     now_count;
        logic [TICK_W-1:0]     start_stamp[NUM_TIMERS];
        bit                    started[NUM_TIMERS];
        logic [TICK_W-1:0]     measured[NUM_TIMERS];
        bit                    miss_flag[NUM_TIMERS];
        logic [TICK_W-1:0]     miss_count[NUM_TIMERS];
        logic [TICK_W-1:0]     latest_miss[NUM_TIMERS];
        logic [TICK_W-1:0]     window_store[NUM_TIMERS][WINDOW_DEPTH];
        int                    window_fill[NUM_TIMERS];
        int                    window_oldest[NUM_TIMERS];
        logic [63:0]           window_total[NUM_TIMERS];

        function new();
            report_errors = 0;
            horizon = 5'd16;
            present = '0;
            now_count = '0;
            for (int s = 0; s < NUM_TIMERS; s++)
            begin
                deadline[s] = '1;
                start_stamp[s] = '0;
                started[s] = 0;
                measured[s] = '0;
                miss_flag[s] = 0;
                miss_count[s] = '0;
                latest_miss[s] = '0;
                window_fill[s] = 0;
                window_oldest[s] = 0;
                window_total[s] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
            case (idx)
                REG_HORIZON:        horizon = data[HORIZON_W-1:0];
                REG_DEADLINE_ZERO:  deadline[0] = data;
                REG_DEADLINE_ONE:   deadline[1] = data;
                REG_DEADLINE_TWO:   deadline[2] = data;
                REG_DEADLINE_THREE: deadline[3] = data;
                REG_PRESENT_MASK:   present = data[MASK_W-1:0];
                default:            ;
            endcase
        endfunction

        function bit slot_exists(int s);
            return started[s] || present[s];
        endfunction

        function void queue_report(timer_report_t r);
            expected_reports.insert(expected_reports.size(), r);
        endfunction

        function timer_report_t make_report(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                            logic okay, logic missed, logic [TICK_W-1:0] total,
                                            logic [TICK_W-1:0] latest, logic [TICK_W-1:0] lastt,
                                            logic [MEAN_W-1:0] mean, logic any_flag,
                                            logic is_last);
            timer_report_t r;
            r.kind = kind;
            r.slot = slot;
            r.ok = okay;
            r.missed = missed;
            r.miss_total = total;
            r.latest_miss = latest;
            r.last_ticks = lastt;
            r.mean = mean;
            r.any_flag = any_flag;
            r.is_last = is_last;
            return r;
        endfunction

        function logic [MEAN_W-1:0] window_push(int s);
            int          h;
            int          pos;
            logic [63:0] quotient;
            h = horizon;
            if (h < 1) h = 1;
            if (h > WINDOW_DEPTH) h = WINDOW_DEPTH;
            while (window_fill[s] >= h)
            begin
                window_total[s] -= 64'(window_store[s][window_oldest[s]]);
                window_oldest[s] = (window_oldest[s] + 1) % WINDOW_DEPTH;
                window_fill[s]--;
            end
            pos = (window_oldest[s] + window_fill[s]) % WINDOW_DEPTH;
            window_store[s][pos] = measured[s];
            window_total[s] += 64'(measured[s]);
            window_fill[s]++;
            quotient = (window_total[s] << FRACTION_BITS) / 64'(window_fill[s]);
            return quotient[MEAN_W-1:0];
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] idx);
            int            k;
            logic          any_flag;
            logic [TICK_W-1:0] d;
            logic [MEAN_W-1:0] mean;
            timer_report_t tail;
            case (op)
                OP_TICK:
                    now_count = now_count + 1'b1;
                OP_START:
                    if (idx >= NUM_TIMERS)
                        queue_report(make_report(KIND_START, idx, 0, 0, '0, '0,
                                                 '0, '0, 0, 1));
                    else
                    begin
                        start_stamp[idx] = now_count;
                        started[idx] = 1;
                        miss_flag[idx] = 0;
                        queue_report(make_report(KIND_START, idx, 1, 0,
                            miss_count[idx], latest_miss[idx], measured[idx], '0, 0, 1));
                    end
                OP_STOP:
                    if (idx >= NUM_TIMERS || !slot_exists(idx))
                        queue_report(make_report(KIND_STOP, idx, 0, 0, '0, '0,
                                                 '0, '0, 0, 1));
                    else
                    begin
                        d = now_count - start_stamp[idx];
                        measured[idx] = d;
                        if (d > deadline[idx])
                        begin
                            miss_flag[idx] = 1;
                            if (miss_count[idx] != '1) miss_count[idx]++;
                            latest_miss[idx] = d;
                        end
                        queue_report(make_report(KIND_STOP, idx, 1,
                            miss_flag[idx], miss_count[idx], latest_miss[idx], measured[idx],
                            '0, 0, 1));
                    end
                default:
                begin
                    k = 0;
                    any_flag = 0;
                    for (int t = 0; t < NUM_TIMERS; t++)
                    begin
                        if (!slot_exists(t)) continue;
                        if (miss_flag[t]) any_flag = 1;
                        mean = window_push(t);
                        queue_report(make_report(KIND_PROFILE, SLOT_W'(t), 1,
                            miss_flag[t], miss_count[t], latest_miss[t], measured[t], mean,
                            0, 0));
                        k++;
                    end
                    if (k == 0)
                        queue_report(make_report(KIND_PROFILE, '0, 0, 0, '0, '0,
                                                 '0, '0, 0, 1));
                    else
                    begin
                        tail = expected_reports[expected_reports.size() - 1];
                        tail.any_flag = any_flag;
                        tail.is_last = 1;
                        expected_reports[expected_reports.size() - 1] = tail;
                    end
                end
            endcase
        endfunction

        function string describe(timer_report_t r);
            return {$sformatf("kind=%0d slot=%0d ok=%0b missed=%0b total=%0h latest=%0h ",
                              r.kind, r.slot, r.ok, r.missed, r.miss_total, r.latest_miss),
                    $sformatf("last_ticks=%0h mean=%0h any=%0b last=%0b",
                              r.last_ticks, r.mean, r.any_flag, r.is_last)};
        endfunction

        function void check_report(timer_report_t seen);
            timer_report_t want;
            if (expected_reports.size() == 0)
            begin
                report_errors++;
                if (report_errors <= REPORT_MAX)
                    $display("Unexpected result: %s", describe(seen));
            end
            else
            begin
                want = expected_reports[0];
                expected_reports.delete(0);
                if (seen !== want)
                begin
                    report_errors++;
                    if (report_errors <= REPORT_MAX)
                    begin
                        $display("Mismatch, expected: %s", describe(want));
                        $display("          actual:   %s", describe(seen));
                    end
                end
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function int failures();
            return report_errors + expected_reports.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [TICK_W-1:0]     cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [OP_W-1:0]       opcode;
    logic [SLOT_W-1:0]     timer_index;
    logic                  out_valid;
    logic                  out_stall;
    logic [KIND_W-1:0]     result_kind;
    logic [SLOT_W-1:0]     slot_index;
    logic                  ok;
    logic                  deadline_missed;
    logic [TICK_W-1:0]     miss_total;
    logic [TICK_W-1:0]     latest_miss_ticks;
    logic [TICK_W-1:0]     last_ticks;
    logic [MEAN_W-1:0]     mean_ticks;
    logic                  any_missed;
    logic                  last;

    timer_scoreboard sb;
    bit              calm = 0;
    bit              long_hold_request = 0;
    int              cycle_count = 0;

    deadline_timer_profiler i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .timer_index       (timer_index),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .result_kind       (result_kind),
        .slot_index        (slot_index),
        .ok                (ok),
        .deadline_missed   (deadline_missed),
        .miss_total        (miss_total),
        .latest_miss_ticks (latest_miss_ticks),
        .last_ticks        (last_ticks),
        .mean_ticks        (mean_ticks),
        .any_missed        (any_missed),
        .last              (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // The receiver stalls in short random bursts and once for a long stretch on request.
    initial
    begin : receiver
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && rst_n && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 8);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        timer_report_t seen;
        if (rst_n === 1'b1 && out_valid && !out_stall)
        begin
            seen.kind = result_kind;
            seen.slot = slot_index;
            seen.ok = ok;
            seen.missed = deadline_missed;
            seen.miss_total = miss_total;
            seen.latest_miss = latest_miss_ticks;
            seen.last_ticks = last_ticks;
            seen.mean = mean_ticks;
            seen.any_flag = any_missed;
            seen.is_last = last;
            sb.check_report(seen);
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] idx);
        in_valid    <= 1'b1;
        opcode      <= op;
        timer_index <= idx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(op, idx);
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] idx);
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        send_request(op, idx);
    endtask

    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic configure(input logic [HORIZON_W-1:0] h, input logic [TICK_W-1:0] d0,
                             input logic [TICK_W-1:0] d1, input logic [TICK_W-1:0] d2,
                             input logic [TICK_W-1:0] d3, input logic [MASK_W-1:0] mask);
        logic [CFG_IDX_W-1:0] idx[6];
        logic [TICK_W-1:0]    val[6];
        idx = '{REG_HORIZON, REG_DEADLINE_ZERO, REG_DEADLINE_ONE, REG_DEADLINE_TWO,
                REG_DEADLINE_THREE, REG_PRESENT_MASK};
        val = '{TICK_W'(h), d0, d1, d2, d3, TICK_W'(mask)};
        wait_idle(16);
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly start, ticks, stop and an occasional profile, with some random requests between.
    task automatic random_traffic(input int count);
        int              sent;
        int              ticks;
        logic [SLOT_W-1:0] s;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                s = SLOT_W'($urandom_range(0, 3));
                issue(OP_START, s);
                ticks = $urandom_range(0, 6);
                repeat (ticks) issue(OP_TICK, SLOT_W'($urandom_range(0, 3)));
                issue(OP_STOP, s);
                sent += ticks + 2;
                if ($urandom_range(0, 2) == 0)
                begin
                    issue(OP_PROFILE, SLOT_W'($urandom_range(0, 3)));
                    sent++;
                end
            end
            else
            begin
                issue(OP_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 3)));
                sent++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        opcode      <= OP_TICK;
        timer_index <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        issue(OP_PROFILE, 2'd0);
        issue(OP_STOP, 2'd1);
        issue(OP_START, 2'd0);
        issue(OP_TICK, 2'd3);
        issue(OP_TICK, 2'd0);
        issue(OP_STOP, 2'd0);
        issue(OP_PROFILE, 2'd3);

        configure(5'd0, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 4'b1010);
        issue(OP_STOP, 2'd3);
        issue(OP_STOP, 2'd1);
        issue(OP_START, 2'd0);
        issue(OP_STOP, 2'd0);
        issue(OP_TICK, 2'd1);
        issue(OP_STOP, 2'd0);
        issue(OP_PROFILE, 2'd1);
        issue(OP_START, 2'd1);
        issue(OP_TICK, 2'd2);
        issue(OP_START, 2'd2);
        issue(OP_TICK, 2'd0);
        issue(OP_TICK, 2'd3);
        issue(OP_STOP, 2'd2);
        issue(OP_PROFILE, 2'd2);
        issue(OP_PROFILE, 2'd0);

        configure(5'd31, $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6),
                  $urandom_range(0, 6), 4'b1111);
        random_traffic(70);

        configure(5'd3, $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 8),
                  $urandom_range(0, 8), 4'b0101);
        random_traffic(30);
        // The receiver holds off while the requests keep coming, so the block backs up.
        long_hold_request = 1;
        for (int i = 0; i < 12; i++)
            send_request((i % 2 == 0) ? OP_START : OP_STOP, SLOT_W'($urandom_range(0, 3)));
        random_traffic(28);

        configure(HORIZON_W'($urandom_range(1, 16)), 32'd0, $urandom, $urandom, $urandom,
                  MASK_W'($urandom_range(0, 15)));
        calm = 1;
        random_traffic(50);

        wait_idle(64);
        if (sb.failures() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
